[sv/qrs_pkg.sv]
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and constants for the quadratic root solver pipeline.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int DATA_WIDTH = 32;
  // square root result width: discriminant stays below 2^(2*DATA_WIDTH+2)
  localparam int SQRT_W     = DATA_WIDTH + 2;
  localparam int DISC_W     = 2 * DATA_WIDTH + 2;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_COMPLEX = 2'd1,
    ST_ONE     = 2'd2,
    ST_TWO     = 2'd3
  } qrs_status_e;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] coef_a;
    logic signed [DATA_WIDTH-1:0] coef_b;
    logic signed [DATA_WIDTH-1:0] coef_c;
  } qrs_in_t;

  typedef struct packed {
    logic [1:0]                   root_status;
    logic signed [DATA_WIDTH-1:0] root_plus;
    logic signed [DATA_WIDTH-1:0] root_minus;
    logic                         overflow;
  } qrs_out_t;

  // side data that rides along the square root stages
  typedef struct packed {
    qrs_status_e                status;
    logic                       a_neg;
    logic [DATA_WIDTH-1:0]      a_mag;
    logic signed [DATA_WIDTH:0] neg_b;
  } qrs_side_t;

  // side data that rides along each divider
  typedef struct packed {
    qrs_status_e status;
    logic        neg;
  } qrs_dside_t;

endpackage

[sv/qrs_front.sv]
// ----------------------------------------------------------------------------
// qrs_front
// Two stages: coefficient magnitudes and products, then the discriminant.
// ----------------------------------------------------------------------------
module qrs_front
  import qrs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  qrs_in_t             data_i,
  output logic                valid_o,
  output logic [DISC_W-1:0]   disc_o,
  output qrs_side_t           side_o
);

  logic [DATA_WIDTH-1:0]   am, bm, cm;
  logic                    v1_q;
  logic                    an_q, bn_q, cn_q, az_q;
  logic [DATA_WIDTH-1:0]   am_q, bm_q;
  logic [2*DATA_WIDTH-1:0] b2_q, ac_q;
  logic [DISC_W-1:0]       b2_ext, p4, d_sum, d_dif, d_d;
  logic                    cplx;
  qrs_status_e             st_d;
  logic signed [DATA_WIDTH:0] nb_d;
  logic                    v2_q;
  logic [DISC_W-1:0]       d_q;
  qrs_side_t               side_q;

  // take magnitudes of the coefficients
  assign am = data_i.coef_a[DATA_WIDTH-1] ? DATA_WIDTH'(-data_i.coef_a) : data_i.coef_a;
  assign bm = data_i.coef_b[DATA_WIDTH-1] ? DATA_WIDTH'(-data_i.coef_b) : data_i.coef_b;
  assign cm = data_i.coef_c[DATA_WIDTH-1] ? DATA_WIDTH'(-data_i.coef_c) : data_i.coef_c;

  // stage 1 and stage 2 valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  // stage 1: products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      an_q <= data_i.coef_a[DATA_WIDTH-1];
      bn_q <= data_i.coef_b[DATA_WIDTH-1];
      cn_q <= data_i.coef_c[DATA_WIDTH-1];
      az_q <= (am == '0);
      am_q <= am;
      bm_q <= bm;
      b2_q <= bm * bm;
      ac_q <= am * cm;
    end
  end

  // stage 2: discriminant and status
  always_comb begin
    b2_ext = DISC_W'(b2_q);
    p4     = {ac_q, 2'b00};
    d_sum  = b2_ext + p4;
    d_dif  = b2_ext - p4;
    cplx   = (an_q == cn_q) && (b2_ext < p4);
    d_d    = (an_q != cn_q) ? d_sum : d_dif;
    if (az_q) begin
      st_d = ST_NONE;
    end else if (cplx) begin
      st_d = ST_COMPLEX;
    end else if (d_d == '0) begin
      st_d = ST_ONE;
    end else begin
      st_d = ST_TWO;
    end
    nb_d = bn_q ? $signed({1'b0, bm_q}) : -$signed({1'b0, bm_q});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q          <= d_d;
      side_q.status <= st_d;
      side_q.a_neg <= an_q;
      side_q.a_mag <= am_q;
      side_q.neg_b <= nb_d;
    end
  end

  assign valid_o = v2_q;
  assign disc_o  = d_q;
  assign side_o  = side_q;

endmodule

[sv/qrs_sqrt.sv]
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined restoring square root, one result bit per stage, truncated.
// ----------------------------------------------------------------------------
module qrs_sqrt
  import qrs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [DISC_W-1:0] rad_i,
  input  qrs_side_t         side_i,
  output logic              valid_o,
  output logic [SQRT_W-1:0] root_o,
  output qrs_side_t         side_o
);

  localparam int REM_W = SQRT_W + 3;
  localparam int X_W   = 2 * SQRT_W;

  logic              vld_q  [SQRT_W];
  logic [REM_W-1:0]  rem_q  [SQRT_W];
  logic [SQRT_W-1:0] root_q [SQRT_W];
  logic [X_W-1:0]    x_q    [SQRT_W];
  qrs_side_t         side_q [SQRT_W];

  for (genvar i = 0; i < SQRT_W; i++) begin : g_stage
    logic              vld_in;
    logic [REM_W-1:0]  rem_in, rem_sh, trial;
    logic [SQRT_W-1:0] root_in;
    logic [X_W-1:0]    x_in;
    qrs_side_t         side_in;
    logic              ge;

    if (i == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = X_W'(rad_i);
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign x_in    = x_q[i-1];
      assign side_in = side_q[i-1];
    end

    // bring down two radicand bits and try the next root bit
    assign rem_sh = {rem_in[REM_W-3:0], x_in[X_W-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= ge ? (rem_sh - trial) : rem_sh;
        root_q[i] <= {root_in[SQRT_W-2:0], ge};
        x_q[i]    <= x_in << 2;
        side_q[i] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[SQRT_W-1];
  assign root_o  = root_q[SQRT_W-1];
  assign side_o  = side_q[SQRT_W-1];

endmodule

[sv/qrs_div.sv]
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined restoring divider for unsigned magnitudes, one quotient bit per
// stage, quotient truncated.
// ----------------------------------------------------------------------------
module qrs_div
  import qrs_pkg::*;
#(
  parameter int NUM_W = 50
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [NUM_W-1:0]   num_i,
  input  logic [DATA_WIDTH:0] den_i,
  input  qrs_dside_t         side_i,
  output logic               valid_o,
  output logic [NUM_W-1:0]   quot_o,
  output qrs_dside_t         side_o
);

  localparam int DEN_W = DATA_WIDTH + 1;
  localparam int REM_W = DEN_W + 1;

  logic             vld_q  [NUM_W];
  logic [REM_W-1:0] rem_q  [NUM_W];
  logic [NUM_W-1:0] quo_q  [NUM_W];
  logic [NUM_W-1:0] num_q  [NUM_W];
  logic [DEN_W-1:0] den_q  [NUM_W];
  qrs_dside_t       side_q [NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic             vld_in;
    logic [REM_W-1:0] rem_in, rem_sh;
    logic [NUM_W-1:0] quo_in, num_in;
    logic [DEN_W-1:0] den_in;
    qrs_dside_t       side_in;
    logic             ge;

    if (i == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign quo_in  = '0;
      assign num_in  = num_i;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign quo_in  = quo_q[i-1];
      assign num_in  = num_q[i-1];
      assign den_in  = den_q[i-1];
      assign side_in = side_q[i-1];
    end

    // shift in the next dividend bit and subtract if it fits
    assign rem_sh = {rem_in[REM_W-2:0], num_in[NUM_W-1]};
    assign ge     = (rem_sh >= {1'b0, den_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= ge ? (rem_sh - {1'b0, den_in}) : rem_sh;
        quo_q[i]  <= {quo_in[NUM_W-2:0], ge};
        num_q[i]  <= num_in << 1;
        den_q[i]  <= den_in;
        side_q[i] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[NUM_W-1];
  assign quot_o  = quo_q[NUM_W-1];
  assign side_o  = side_q[NUM_W-1];

endmodule

[sv/quadratic_root_solver_top.sv]
// ----------------------------------------------------------------------------
// quadratic_root_solver_top
// Real roots of a*x^2 + b*x + c in signed Q16.16, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  | signals                           | payload
//  ---------+-----------------------------------+-----------
//  input    | in_valid_i, in_stall_o, in_data_i | qrs_in_t
//  output   | out_valid_o, out_stall_i, out_data_o | qrs_out_t
//
//  One coefficient set enters per cycle unless the pipeline is stalled; each gives one result.
//  A result passes the front end, the bit-per-stage square root, the numerator
//  register, the bit-per-stage dividers and the output register.
//  Reset clears only the valid bits; no clearing pass is needed.
//  A stalled result holds the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module quadratic_root_solver_top
  import qrs_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  qrs_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output qrs_out_t out_data_o
);

  localparam int MAG_W = DATA_WIDTH + 2;
  localparam int NUM_W = MAG_W + FRAC_BITS;

  logic              en;
  logic              fr_valid;
  logic [DISC_W-1:0] fr_disc;
  qrs_side_t         fr_side;
  logic              sq_valid;
  logic [SQRT_W-1:0] sq_root;
  qrs_side_t         sq_side;

  logic signed [MAG_W:0] np, nm;
  logic                  n_valid_q;
  logic [NUM_W-1:0]      np_num_q, nm_num_q;
  logic [DATA_WIDTH:0]   den_q;
  qrs_dside_t            p_side_q, m_side_q;

  logic             dp_valid, dm_valid;
  logic [NUM_W-1:0] dp_quot, dm_quot;
  qrs_dside_t       dp_side, dm_side;

  logic [NUM_W-1:0]      lim_p, lim_m;
  logic                  sat_p, sat_m;
  logic [DATA_WIDTH-1:0] mag_p, mag_m;
  qrs_out_t              res_d;
  logic                  out_valid_q;
  qrs_out_t              out_q;

  // advance everything unless a finished result is held
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  qrs_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (fr_valid),
    .disc_o  (fr_disc),
    .side_o  (fr_side)
  );

  qrs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .rad_i   (fr_disc),
    .side_i  (fr_side),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // form -b + s and -b - s
  assign np = (MAG_W+1)'(sq_side.neg_b) + $signed({1'b0, sq_root});
  assign nm = (MAG_W+1)'(sq_side.neg_b) - $signed({1'b0, sq_root});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_valid_q <= 1'b0;
    end else if (en) begin
      n_valid_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      np_num_q        <= NUM_W'(np[MAG_W] ? MAG_W'(-np) : MAG_W'(np)) << FRAC_BITS;
      nm_num_q        <= NUM_W'(nm[MAG_W] ? MAG_W'(-nm) : MAG_W'(nm)) << FRAC_BITS;
      den_q           <= {sq_side.a_mag, 1'b0};
      p_side_q.status <= sq_side.status;
      p_side_q.neg    <= np[MAG_W] ^ sq_side.a_neg;
      m_side_q.status <= sq_side.status;
      m_side_q.neg    <= nm[MAG_W] ^ sq_side.a_neg;
    end
  end

  qrs_div #(.NUM_W(NUM_W)) u_div_plus (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (n_valid_q),
    .num_i   (np_num_q),
    .den_i   (den_q),
    .side_i  (p_side_q),
    .valid_o (dp_valid),
    .quot_o  (dp_quot),
    .side_o  (dp_side)
  );

  qrs_div #(.NUM_W(NUM_W)) u_div_minus (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (n_valid_q),
    .num_i   (nm_num_q),
    .den_i   (den_q),
    .side_i  (m_side_q),
    .valid_o (dm_valid),
    .quot_o  (dm_quot),
    .side_o  (dm_side)
  );

  // saturate, restore sign, zero the roots when there is no real root
  always_comb begin
    lim_p = dp_side.neg ? (NUM_W'(1) << (DATA_WIDTH-1))
                        : ((NUM_W'(1) << (DATA_WIDTH-1)) - NUM_W'(1));
    lim_m = dm_side.neg ? (NUM_W'(1) << (DATA_WIDTH-1))
                        : ((NUM_W'(1) << (DATA_WIDTH-1)) - NUM_W'(1));
    sat_p = dp_quot > lim_p;
    sat_m = dm_quot > lim_m;
    mag_p = sat_p ? lim_p[DATA_WIDTH-1:0] : dp_quot[DATA_WIDTH-1:0];
    mag_m = sat_m ? lim_m[DATA_WIDTH-1:0] : dm_quot[DATA_WIDTH-1:0];
    res_d.root_status = dp_side.status;
    if (dp_side.status == ST_ONE || dp_side.status == ST_TWO) begin
      res_d.root_plus  = dp_side.neg ? -mag_p : mag_p;
      res_d.root_minus = dm_side.neg ? -mag_m : mag_m;
      res_d.overflow   = sat_p | sat_m;
    end else begin
      res_d.root_plus  = '0;
      res_d.root_minus = '0;
      res_d.overflow   = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dp_valid & dm_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[sv/qrs_checker.sv]
// ----------------------------------------------------------------------------
// qrs_checker
// Port-level checks for the quadratic root solver, bound to the top level.
// ----------------------------------------------------------------------------
module qrs_checker
  import qrs_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input qrs_out_t out_data_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // input stall only while a result waits on a stalled consumer
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // no real root gives zero root fields
  a_zero_roots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.root_status == ST_NONE ||
                    out_data_o.root_status == ST_COMPLEX)
    |-> out_data_o.root_plus == '0 && out_data_o.root_minus == '0 &&
        !out_data_o.overflow)
    else $error("roots present without a real root");

  // a double root shows the same value twice
  a_double_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.root_status == ST_ONE
    |-> out_data_o.root_plus == out_data_o.root_minus)
    else $error("double root mismatch");

endmodule

bind quadratic_root_solver_top qrs_checker u_qrs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
